// ----- rtl/sbt_pkg.sv -----
// shared types and constants of the sine burst tone generator
// state encoding, controller/datapath command and status structs, reset values
package sbt_pkg;

    // default sine table depth
    localparam int SBT_SINE_ENTRIES = 1024;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE_INCREMENT = 2'd0;
    localparam logic [1:0] CFG_BURST_LOG2     = 2'd1;
    localparam logic [1:0] CFG_AMPLITUDE      = 2'd2;

    // configuration reset values
    localparam logic [31:0] BASE_INCREMENT_RST = 32'd24801889;
    localparam logic [2:0]  BURST_LOG2_RST     = 3'd3;
    localparam logic [22:0] AMPLITUDE_RST      = 23'd4194304;

    localparam real HALF_PI = 1.5707963267948966;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PITCH,
        ST_LATCH,
        ST_ADDR,
        ST_ROM,
        ST_MUL,
        ST_EMIT
    } sbt_state_t;

    typedef struct packed {
        logic load_in;
        logic pitch_mul;
        logic pitch_latch;
        logic addr;
        logic rom;
        logic mul;
        logic emit;
    } sbt_cmd_t;

    typedef struct packed {
        logic start_pending;
        logic out_free;
    } sbt_status_t;

endpackage

// ----- rtl/sine_burst_tone_generator_unit.sv -----
// top level of the sine burst tone generator
// depends on sbt_pkg, sbt_ctrl and sbt_datapath
//
//   channel   direction  handshake             payload
//   s_*       in         s_tvalid / s_tready   s_tdata: start_note, pitch_step
//   m_*       out        m_tvalid / m_tready   m_tdata: sample, m_tuser: burst_active
//   cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// a tick runs from transfer to the next s_tready, with the note latch step added when it starts a note;
// the controller steps one item at a time through pitch multiply,
// note latch (start only), phase/address, sine rom read with envelope multiply,
// sample multiply and output write
// rst_n is asynchronous, active low; it restores the register reset values and silences
// the output until the first note start
// a stalled m_tready holds the finished sample in the output register; the next tick
// is still taken and waits only at the last step until the output register frees
module sine_burst_tone_generator_unit
    import sbt_pkg::*;
#(
    parameter int SINE_ENTRIES = SBT_SINE_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_note, [4:1] pitch_step, [7:5] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] sample, two's complement
    output logic [0:0]  m_tuser,   // [0] burst_active
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    sbt_cmd_t    cmd;
    sbt_status_t status;
    logic        cfg_we;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencing of one tick
    sbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, state and output register
    sbt_datapath #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_start   (s_tdata[0]),
        .in_step    (s_tdata[4:1]),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_sample (m_tdata),
        .out_active (m_tuser[0])
    );

endmodule

// ----- rtl/sbt_ctrl.sv -----
// controller state machine of the sine burst tone generator
// depends on sbt_pkg; drives the datapath through sbt_cmd_t
module sbt_ctrl
    import sbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  sbt_status_t status,
    output sbt_cmd_t    cmd
);

    sbt_state_t state_reg;
    sbt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PITCH;
                end
            end
            ST_PITCH:
            begin
                cmd.pitch_mul = 1'b1;
                state_next    = status.start_pending ? ST_LATCH : ST_ADDR;
            end
            ST_LATCH:
            begin
                cmd.pitch_latch = 1'b1;
                state_next      = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = ST_ROM;
            end
            ST_ROM:
            begin
                cmd.rom    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sbt_datapath.sv -----
// datapath of the sine burst tone generator: config registers, pitch,
// phase accumulator, sine rom, envelope and sample multipliers, output register
// depends on sbt_pkg; steered by sbt_ctrl through sbt_cmd_t
module sbt_datapath
    import sbt_pkg::*;
#(
    parameter int SINE_ENTRIES = SBT_SINE_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_start,
    input  logic [3:0]  in_step,
    input  sbt_cmd_t    cmd,
    output sbt_status_t status,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [23:0] out_sample,
    output logic        out_active
);

    localparam int  IDX_W      = $clog2(SINE_ENTRIES);
    localparam real SINE_RECIP = 1.0 / SINE_ENTRIES;
    localparam logic [IDX_W:0] N_VAL = (IDX_W + 1)'(SINE_ENTRIES);
    localparam logic [38:0] PHASE_MAX = {39{1'b1}};
    localparam logic [33:0] ONE_Q32   = 34'h1_0000_0000;
    localparam logic [33:0] TWO_Q32   = 34'h2_0000_0000;

    // equal-division ratios, round(65536 * 2^(k/5))
    function automatic logic [16:0] ratio_q16(input logic [2:0] k);
        logic [16:0] r;
        begin
            case (k)
                3'd1:    r = 17'd75281;
                3'd2:    r = 17'd86475;
                3'd3:    r = 17'd99334;
                3'd4:    r = 17'd114105;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction

    // octave of a pitch step, step div 5
    function automatic logic [1:0] step_octave(input logic [3:0] s);
        logic [1:0] o;
        begin
            if (s >= 4'd15)
                o = 2'd3;
            else if (s >= 4'd10)
                o = 2'd2;
            else if (s >= 4'd5)
                o = 2'd1;
            else
                o = 2'd0;
            return o;
        end
    endfunction

    // magnitude of sine table entry k, round(2^23 * |sin|) clipped
    function automatic logic [22:0] sine_mag(input int k, input int n, input real recip);
        int  quad;
        int  r;
        int  m;
        int  vi;
        real x;
        real v;
        begin
            if (4 * k < n)
                quad = 0;
            else if (4 * k < 2 * n)
                quad = 1;
            else if (4 * k < 3 * n)
                quad = 2;
            else
                quad = 3;
            r  = 4 * k - quad * n;
            m  = (quad == 1 || quad == 3) ? (n - r) : r;
            x  = real'(m) * HALF_PI * recip;
            v  = $floor($sin(x) * 8388608.0 + 0.5);
            if (v > 8388607.0)
                v = 8388607.0;
            vi = $rtoi(v);
            return vi[22:0];
        end
    endfunction

    logic [22:0] sine_rom [SINE_ENTRIES];

    for (genvar g = 0; g < SINE_ENTRIES; g++)
    begin : g_rom
        assign sine_rom[g] = sine_mag(g, SINE_ENTRIES, SINE_RECIP);
    end

    logic [31:0]      base_inc_reg;
    logic [2:0]       burst_log2_reg;
    logic [22:0]      amplitude_reg;
    logic             start_reg;
    logic [3:0]       step_reg;
    logic [48:0]      pitch_prod_reg;
    logic [36:0]      note_inc_reg;
    logic [38:0]      phase_reg;
    logic             started_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [16:0]      tri_reg;
    logic             active_reg;
    logic [22:0]      sine_reg;
    logic             neg_reg;
    logic [39:0]      amp_tri_reg;
    logic [62:0]      prod_reg;
    logic             out_valid_reg;
    logic [23:0]      sample_reg;
    logic             out_active_reg;

    logic [1:0]          octave;
    logic [2:0]          ratio_k;
    logic [2:0]          lg;
    logic                in_window;
    logic [38:0]         u_full;
    logic [33:0]         tri_q32;
    logic [32+IDX_W:0]   idx_prod;
    logic [39:0]         phase_sum;
    logic [38:0]         phase_next;
    logic [23:0]         mag;
    logic [23:0]         sample_next;

    always_comb
    begin
        octave  = step_octave(step_reg);
        ratio_k = 3'(step_reg - ({2'b00, octave} * 4'd5));

        // burst length clamped to one through six
        if (burst_log2_reg == 3'd0)
            lg = 3'd1;
        else if (burst_log2_reg == 3'd7)
            lg = 3'd6;
        else
            lg = burst_log2_reg;

        in_window = ((phase_reg >> (6'd32 + {3'b000, lg})) == 39'd0);

        // triangle envelope over the burst
        u_full  = phase_reg >> (lg - 3'd1);
        tri_q32 = (u_full[33:0] <= ONE_Q32) ? u_full[33:0] : (TWO_Q32 - u_full[33:0]);

        idx_prod = {{(IDX_W + 1){1'b0}}, phase_reg[31:0]} * {32'd0, N_VAL};

        // saturating phase advance
        phase_sum  = {1'b0, phase_reg} + {3'b000, note_inc_reg};
        phase_next = phase_sum[39] ? PHASE_MAX : phase_sum[38:0];

        mag = prod_reg[62:39];
        if (!active_reg)
            sample_next = 24'd0;
        else if (neg_reg)
            sample_next = 24'd0 - mag;
        else
            sample_next = mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_inc_reg   <= BASE_INCREMENT_RST;
            burst_log2_reg <= BURST_LOG2_RST;
            amplitude_reg  <= AMPLITUDE_RST;
            start_reg      <= 1'b0;
            note_inc_reg   <= '0;
            phase_reg      <= '0;
            started_reg    <= 1'b0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE_INCREMENT: base_inc_reg   <= cfg_data;
                    CFG_BURST_LOG2:     burst_log2_reg <= cfg_data[2:0];
                    CFG_AMPLITUDE:      amplitude_reg  <= cfg_data[22:0];
                    default:            ;
                endcase
            end
            if (cmd.load_in)
            begin
                start_reg <= in_start;
            end
            if (cmd.pitch_latch)
            begin
                note_inc_reg <= {4'b0000, pitch_prod_reg[48:16]} << octave;
                phase_reg    <= '0;
                started_reg  <= 1'b1;
            end
            if (cmd.addr)
            begin
                active_reg <= started_reg && in_window;
                if (started_reg)
                    phase_reg <= phase_next;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            step_reg <= in_step;
        if (cmd.pitch_mul)
            pitch_prod_reg <= {17'd0, base_inc_reg} * {32'd0, ratio_q16(ratio_k)};
        if (cmd.addr)
        begin
            idx_reg <= idx_prod[32 +: IDX_W];
            tri_reg <= tri_q32[32:16];
        end
        if (cmd.rom)
        begin
            sine_reg    <= sine_rom[idx_reg];
            neg_reg     <= ({1'b0, idx_reg} << 1) >= {1'b0, N_VAL};
            amp_tri_reg <= {17'd0, amplitude_reg} * {23'd0, tri_reg};
        end
        if (cmd.mul)
            prod_reg <= {40'd0, sine_reg} * {23'd0, amp_tri_reg};
        if (cmd.emit)
        begin
            sample_reg     <= sample_next;
            out_active_reg <= active_reg;
        end
    end

    assign status.start_pending = start_reg;
    assign status.out_free      = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_sample = sample_reg;
    assign out_active = out_active_reg;

endmodule

// ----- rtl/sbt_checker.sv -----
// port-level checks of the sine burst tone generator
// depends on the top level ports only; bound to sine_burst_tone_generator_unit
module sbt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one tick in flight: a transfer closes the input side for the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a tick is in flight");

    // outside the burst window the sample is silent
    a_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 24'd0)
        else $error("nonzero sample outside the burst");

    // magnitude stays below 2^23, so the most negative code never shows
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata != 24'h800000)
        else $error("sample out of range");

    // a new result appears only while the block was busy with a tick
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a tick in flight");

endmodule

bind sine_burst_tone_generator_unit sbt_checker u_sbt_checker (.*);

// ----- test/sine_burst_tone_generator_unit_test.sv -----
// self-checking bench for sine_burst_tone_generator_unit: random tone bursts, one sample per tick
// needs sbt_pkg and the unit itself; carries its own integer tone model to predict every sample
`timescale 1ns / 1ps

module sine_burst_tone_generator_unit_test;
    import sbt_pkg::*;

    localparam int          SINE_ENTRIES    = SBT_SINE_ENTRIES;
    localparam logic [1:0]  CFG_UNUSED      = 2'd3;
    localparam logic [63:0] HALF_PI_Q62     = 64'h6487ED5110B4611A;
    localparam logic [63:0] PHASE_MAX       = (64'd1 << 39) - 64'd1;
    localparam int          NUM_PHASES      = 12;
    localparam int          TICKS_PER_PHASE = 116;
    localparam int          QUIET_PHASES    = 2;      // last phases run with no gaps or stalls
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          CYCLE_LIMIT     = 400000;

    // one input tick, packed as it sits in s_tdata[4:0]
    typedef struct packed {
        logic [3:0] pitch_step;
        logic       start_note;
    } tick_t;

    typedef struct packed {
        logic [23:0] sample;
        logic        burst_active;
    } tone_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;

    // tone model: register copies, oscillator state and sine table
    logic [31:0] cfg_base       = BASE_INCREMENT_RST;
    logic [2:0]  cfg_burst_log2 = BURST_LOG2_RST;
    logic [22:0] cfg_amplitude  = AMPLITUDE_RST;
    logic [63:0] tone_phase     = 64'd0;
    logic [63:0] note_step      = 64'd0;
    logic        note_on        = 1'b0;
    int          sine_lut [SINE_ENTRIES];

    tick_t        pending_ticks[$];
    tone_result_t expected_samples[$];
    tone_result_t oldest_sample;

    int source_gap      = 0;
    int sink_stall      = 0;
    bit source_idle_on  = 1'b1;
    bit sink_stall_on   = 1'b1;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    sine_burst_tone_generator_unit #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit, far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // five-per-octave ratios in q1.16
    function automatic logic [63:0] pitch_ratio(input logic [3:0] k);
        case (k)
            4'd0:    return 64'd65536;
            4'd1:    return 64'd75281;
            4'd2:    return 64'd86475;
            4'd3:    return 64'd99334;
            default: return 64'd114105;
        endcase
    endfunction

    // (a * b) >> 62 over the full 128-bit product
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // sin(x) on [0, pi/2] in q62, alternating taylor series
    function automatic logic [63:0] sine_q62(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2 = mul_q62(x, x);
        term = x;
        sum = x;
        for (int n = 1; n <= 20; n++)
        begin
            term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    // quarter-wave folded table, rounded to 24 bits and clipped at full scale
    task automatic build_sine_lut();
        logic [63:0] n;
        logic [63:0] qstep;
        logic [63:0] qrem;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] v;
        n = 64'(SINE_ENTRIES);
        qstep = HALF_PI_Q62 / n;
        qrem = HALF_PI_Q62 % n;
        for (int k = 0; k < SINE_ENTRIES; k++)
        begin
            quad = (64'd4 * 64'(k)) / n;
            r = 64'd4 * 64'(k) - quad * n;
            m = quad[0] ? (n - r) : r;
            x = qstep * m + (qrem * m) / n;
            v = (sine_q62(x) + (64'd1 << 38)) >> 39;
            if (v > 64'd8388607)
                v = 64'd8388607;
            sine_lut[k] = (quad >= 64'd2) ? -int'(v) : int'(v);
        end
    endtask

    // one sample tick: note start first, then the sample from the current phase, then advance
    function automatic tone_result_t play_tick(input tick_t t);
        int unsigned  lg;
        logic [63:0]  idx;
        logic [63:0]  u;
        logic [63:0]  ramp;
        logic [63:0]  env;
        logic [63:0]  mag;
        logic [63:0]  next;
        logic [63:0]  sm;
        int           sv;
        tone_result_t res;
        lg = cfg_burst_log2;
        if (lg < 1)
            lg = 1;
        if (lg > 6)
            lg = 6;
        if (t.start_note)
        begin
            note_step = ((64'(cfg_base) * pitch_ratio(t.pitch_step % 5)) >> 16)
                        << (t.pitch_step / 5);
            tone_phase = 64'd0;
            note_on = 1'b1;
        end
        res.sample = 24'd0;
        res.burst_active = 1'b0;
        if (note_on && tone_phase < (64'd1 << (32 + lg)))
        begin
            idx = ((tone_phase & 64'hFFFF_FFFF) * 64'(SINE_ENTRIES)) >> 32;
            sv = sine_lut[idx];
            // triangle envelope, peak at half the burst
            u = tone_phase >> (lg - 1);
            ramp = (u <= 64'h1_0000_0000) ? u : (64'h2_0000_0000 - u);
            env = ramp >> 16;
            sm = 64'((sv < 0) ? -sv : sv);
            mag = (sm * 64'(cfg_amplitude) * env) >> 39;
            // sign applied after the multiply, so truncation is toward zero
            res.sample = (sv < 0) ? 24'(-mag) : 24'(mag);
            res.burst_active = 1'b1;
        end
        if (note_on)
        begin
            next = tone_phase + note_step;
            tone_phase = (next > PHASE_MAX) ? PHASE_MAX : next;
        end
        return res;
    endfunction

    // stream source: takes the next tick from the queue, predicts on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                expected_samples.push_back(play_tick(tick_t'(s_tdata[4:0])));
            if (source_gap > 0)
            begin
                source_gap = source_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_ticks.size() != 0 && source_idle_on
                     && $urandom_range(0, 7) == 0)
            begin
                // idle burst: s_tvalid drops and source_gap is drawn from 0 to 2
                source_gap = $urandom_range(0, 2);
                s_tvalid <= 1'b0;
            end
            else if (pending_ticks.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {3'b000, pending_ticks.pop_front()};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result sink: random stalls, every transfer checked against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("output transfer with no sample expected: sample %0d, active %0b",
                           $signed(m_tdata), m_tuser[0]);
                    mismatch_count++;
                end
                else
                begin
                    oldest_sample = expected_samples.pop_front();
                    if (m_tdata !== oldest_sample.sample)
                    begin
                        $error("sample mismatch: expected %0d, actual %0d",
                               $signed(oldest_sample.sample), $signed(m_tdata));
                        mismatch_count++;
                    end
                    if (m_tuser[0] !== oldest_sample.burst_active)
                    begin
                        $error("burst_active mismatch: expected %0b, actual %0b",
                               oldest_sample.burst_active, m_tuser[0]);
                        mismatch_count++;
                    end
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall = sink_stall - 1;
                m_tready <= 1'b0;
            end
            else if (sink_stall_on && $urandom_range(0, 5) == 0)
            begin
                sink_stall = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // register write, model copy updated on the transfer
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BASE_INCREMENT: cfg_base = data;
            CFG_BURST_LOG2:     cfg_burst_log2 = data[2:0];
            CFG_AMPLITUDE:      cfg_amplitude = data[22:0];
            default:            ;
        endcase
    endtask

    // wait until every tick is taken and every sample checked, then let the unit settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_ticks.size() != 0 || s_tvalid || expected_samples.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // a note: one start tick then len plain ticks with junk in the ignored pitch field
    task automatic queue_note(input logic [3:0] step, input int len);
        pending_ticks.push_back('{pitch_step: step, start_note: 1'b1});
        for (int i = 0; i < len; i++)
            pending_ticks.push_back('{pitch_step: 4'($urandom_range(0, 15)),
                                      start_note: 1'b0});
    endtask

    initial
    begin
        int unsigned lg_raw;
        int unsigned lg_eff;
        logic [63:0] wide;
        logic [31:0] base_value;
        logic [22:0] amp_value;
        int          burst_ticks;
        int          queued;
        int          len;

        build_sine_lut();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: silence before the first note, then a note at reset settings
        pending_ticks.push_back('{pitch_step: 4'hF, start_note: 1'b0});
        pending_ticks.push_back('{pitch_step: 4'h0, start_note: 1'b0});
        pending_ticks.push_back('{pitch_step: 4'hA, start_note: 1'b0});
        queue_note(4'd15, 1);
        wait_drained();

        // largest base increment, shortest burst (zero read as one), full amplitude:
        // burst ends after one sample, phase then runs into saturation
        write_register(CFG_BASE_INCREMENT, 32'hFFFF_FFFF);
        write_register(CFG_BURST_LOG2, 32'hFFFF_FFF8);
        write_register(CFG_AMPLITUDE, 32'h007F_FFFF);
        write_register(CFG_UNUSED, 32'h0000_0001);
        queue_note(4'd14, 19);
        wait_drained();

        // random phases, each with its own settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            source_idle_on = (p < NUM_PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
            sink_stall_on = (p < NUM_PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);

            // burst length walks through all eight codes, 0 and 7 included
            lg_raw = p % 8;
            lg_eff = (lg_raw < 1) ? 1 : ((lg_raw > 6) ? 6 : lg_raw);

            if (p == 3)
                base_value = 32'd0;
            else if (p == 4)
                base_value = 32'hFFFF_FFFF;
            else if (p == 5)
                base_value = $urandom();
            else
            begin
                // aim for a burst of a few dozen ticks at the lowest pitch
                wide = (64'd1 << (32 + lg_eff)) / 64'($urandom_range(24, 120));
                base_value = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
            end

            if (p == 1)
                amp_value = 23'd0;
            else if (p == 2)
                amp_value = 23'h7F_FFFF;
            else
                amp_value = 23'($urandom_range(1, 23'h7F_FFFF));

            write_register(CFG_BASE_INCREMENT, base_value);
            write_register(CFG_BURST_LOG2, {29'($urandom()), 3'(lg_raw)});
            write_register(CFG_AMPLITUDE, {9'($urandom()), amp_value});
            write_register(CFG_UNUSED, $urandom());

            if (base_value == 32'd0)
                burst_ticks = 160;
            else
            begin
                wide = (64'd1 << (32 + lg_eff)) / 64'(base_value);
                burst_ticks = (wide > 64'd160) ? 160 : int'(wide);
            end

            queued = 0;
            while (queued < TICKS_PER_PHASE)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // mostly notes, some cut short by the next start, some run past the burst
                    len = $urandom_range(0, burst_ticks + 8);
                    queue_note(4'($urandom_range(0, 15)), len);
                    queued += len + 1;
                end
                else
                begin
                    // loose ticks with occasional restarts
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        pending_ticks.push_back('{pitch_step: 4'($urandom_range(0, 15)),
                                                  start_note: ($urandom_range(0, 3) == 0)});
                    queued += len;
                end
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
